>>> sv/lsdm_pkg.sv
// Shared types, constants and helpers for the RV32I load/store data memory.
// No dependencies; every other file of the block refers to this package.
package lsdm_pkg;

    // Memory size in bytes; a power of two, byte addresses wrap modulo this size
    localparam int MEM_SIZE_BYTES = 65536;
    localparam int LANES          = 4;
    localparam int ADDR_W         = $clog2(MEM_SIZE_BYTES);
    localparam int ROWS           = MEM_SIZE_BYTES / LANES;
    localparam int ROW_W          = ADDR_W - 2;

    typedef enum logic [1:0] {
        OP_READ       = 2'd0,
        OP_WRITE_REQ  = 2'd1,
        OP_WRITE_DATA = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_LB  = 3'd0,
        KIND_LBU = 3'd1,
        KIND_LH  = 3'd2,
        KIND_LHU = 3'd3,
        KIND_LW  = 3'd4,
        KIND_SB  = 3'd5,
        KIND_SH  = 3'd6,
        KIND_SW  = 3'd7
    } kind_t;

    typedef enum logic {
        RESP_READ = 1'b0,
        RESP_DONE = 1'b1
    } resp_t;

    // Per-lane memory command for one cycle
    typedef struct packed {
        logic [LANES-1:0]            rd_en;
        logic [LANES-1:0]            wr_en;
        logic [LANES-1:0][ROW_W-1:0] row;
        logic [LANES-1:0][7:0]       wdata;
    } mem_cmd_t;

    // Item in flight between the memory read and the result register
    typedef struct packed {
        logic       valid;
        resp_t      rsp;
        kind_t      kind;
        logic [1:0] off;
        logic [4:0] dest;
        logic [4:0] src;
    } stage_t;

    // Number of bytes a load kind reads; store kinds read nothing
    function automatic logic [2:0] load_count(kind_t kind);
        logic [2:0] n;
        case (kind)
            KIND_LB, KIND_LBU: n = 3'd1;
            KIND_LH, KIND_LHU: n = 3'd2;
            KIND_LW:           n = 3'd4;
            default:           n = 3'd0;
        endcase
        return n;
    endfunction

    // Number of bytes a store writes; SW is capped at four, load kinds write nothing
    function automatic logic [2:0] store_count(kind_t kind, logic [2:0] vbytes);
        logic [2:0] n;
        case (kind)
            KIND_SB: n = 3'd1;
            KIND_SH: n = 3'd2;
            KIND_SW: n = (vbytes > 3'd4) ? 3'd4 : vbytes;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> sv/lsdm_byte_ram.sv
// One byte lane of the data memory: single port, registered read data.
// Depends on lsdm_pkg for the row count and width.
module lsdm_byte_ram (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic                       wr_en,
    input  logic [lsdm_pkg::ROW_W-1:0] row,
    input  logic [7:0]                 wdata,
    output logic [7:0]                 rdata
);

    logic [7:0] store_mem [lsdm_pkg::ROWS];
    logic [7:0] rdata_reg;

    // Write the addressed row, capture read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[row] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/lsdm_access.sv
// Request side: write pairing, byte-lane address split, clearing pass and
// the stage register for items waiting on memory read data. Uses lsdm_pkg.
module lsdm_access (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [2:0]           access_kind,
    input  logic [31:0]          address,
    input  logic [31:0]          write_data,
    input  logic [2:0]           valid_bytes,
    input  logic [4:0]           dest_reg,
    input  logic [4:0]           source_reg,
    input  logic                 s1_ready,
    output lsdm_pkg::stage_t     s1,
    output lsdm_pkg::mem_cmd_t   cmd
);

    // Held write halves
    logic                           held_req_valid_reg,  held_req_valid_next;
    logic [31:0]                    held_req_addr_reg,   held_req_addr_next;
    lsdm_pkg::kind_t                held_req_kind_reg,   held_req_kind_next;
    logic                           held_data_valid_reg, held_data_valid_next;
    logic [31:0]                    held_data_word_reg,  held_data_word_next;
    logic [2:0]                     held_data_count_reg, held_data_count_next;

    // Clearing pass after reset
    logic                           clear_reg,     clear_next;
    logic [lsdm_pkg::ROW_W-1:0]     clear_row_reg, clear_row_next;

    lsdm_pkg::stage_t               s1_reg, s1_next;

    logic                           accept;
    logic                           produce;
    logic                           is_read;
    logic                           is_write;
    lsdm_pkg::resp_t                rsp;
    lsdm_pkg::kind_t                in_kind;
    logic [31:0]                    acc_addr;
    logic [31:0]                    acc_word;
    logic [2:0]                     acc_count;
    logic [1:0]                     off;
    logic [lsdm_pkg::ROW_W-1:0]     base_row;
    logic [1:0]                     idx [lsdm_pkg::LANES];
    logic                           lane_on [lsdm_pkg::LANES];

    assign in_kind  = lsdm_pkg::kind_t'(access_kind);
    assign in_ready = !clear_reg && (!s1_reg.valid || s1_ready);
    assign accept   = in_valid && in_ready;

    // Decode the word and pair write halves
    always_comb
    begin
        held_req_valid_next  = held_req_valid_reg;
        held_req_addr_next   = held_req_addr_reg;
        held_req_kind_next   = held_req_kind_reg;
        held_data_valid_next = held_data_valid_reg;
        held_data_word_next  = held_data_word_reg;
        held_data_count_next = held_data_count_reg;
        produce   = 1'b0;
        is_read   = 1'b0;
        is_write  = 1'b0;
        rsp       = lsdm_pkg::RESP_READ;
        acc_addr  = address;
        acc_word  = write_data;
        acc_count = 3'd0;
        case (lsdm_pkg::op_t'(operation))
            lsdm_pkg::OP_READ:
            begin
                produce   = 1'b1;
                is_read   = 1'b1;
                acc_count = lsdm_pkg::load_count(in_kind);
            end
            lsdm_pkg::OP_WRITE_REQ:
            begin
                if (held_data_valid_reg)
                begin
                    produce              = 1'b1;
                    is_write             = 1'b1;
                    rsp                  = lsdm_pkg::RESP_DONE;
                    acc_word             = held_data_word_reg;
                    acc_count            = lsdm_pkg::store_count(in_kind, held_data_count_reg);
                    held_data_valid_next = 1'b0;
                end
                else
                begin
                    held_req_valid_next = 1'b1;
                    held_req_addr_next  = address;
                    held_req_kind_next  = in_kind;
                end
            end
            lsdm_pkg::OP_WRITE_DATA:
            begin
                if (held_req_valid_reg)
                begin
                    produce             = 1'b1;
                    is_write            = 1'b1;
                    rsp                 = lsdm_pkg::RESP_DONE;
                    acc_addr            = held_req_addr_reg;
                    acc_count           = lsdm_pkg::store_count(held_req_kind_reg, valid_bytes);
                    held_req_valid_next = 1'b0;
                end
                else
                begin
                    held_data_valid_next = 1'b1;
                    held_data_word_next  = write_data;
                    held_data_count_next = valid_bytes;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Split the access over the byte lanes; a lane below the offset wraps to the next row
    assign off      = acc_addr[1:0];
    assign base_row = acc_addr[lsdm_pkg::ADDR_W-1:2];

    always_comb
    begin
        for (int j = 0; j < lsdm_pkg::LANES; j++)
        begin
            idx[j]         = 2'(j) - off;
            lane_on[j]     = {1'b0, idx[j]} < acc_count;
            cmd.rd_en[j]   = accept && is_read && lane_on[j];
            cmd.wr_en[j]   = accept && is_write && lane_on[j];
            cmd.row[j]     = base_row + lsdm_pkg::ROW_W'((2'(j) < off) ? 1 : 0);
            cmd.wdata[j]   = acc_word[8*idx[j] +: 8];
            if (clear_reg)
            begin
                cmd.rd_en[j] = 1'b0;
                cmd.wr_en[j] = 1'b1;
                cmd.row[j]   = clear_row_reg;
                cmd.wdata[j] = 8'h00;
            end
        end
    end

    // Step the clearing pass one row per cycle
    always_comb
    begin
        clear_next     = clear_reg;
        clear_row_next = clear_row_reg;
        if (clear_reg)
        begin
            clear_row_next = clear_row_reg + 1'b1;
            if (clear_row_reg == lsdm_pkg::ROW_W'(lsdm_pkg::ROWS - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    // Load the stage register when it is empty or moves on
    always_comb
    begin
        s1_next = s1_reg;
        if (!s1_reg.valid || s1_ready)
        begin
            s1_next.valid = accept && produce;
            s1_next.rsp   = rsp;
            s1_next.kind  = in_kind;
            s1_next.off   = off;
            s1_next.dest  = dest_reg;
            s1_next.src   = source_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_req_valid_reg  <= 1'b0;
            held_data_valid_reg <= 1'b0;
            clear_reg           <= 1'b1;
            clear_row_reg       <= '0;
            s1_reg              <= '0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_row_reg <= clear_row_next;
            s1_reg        <= s1_next;
            if (accept)
            begin
                held_req_valid_reg  <= held_req_valid_next;
                held_data_valid_reg <= held_data_valid_next;
            end
        end
    end

    // Held payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_req_addr_reg   <= held_req_addr_next;
            held_req_kind_reg   <= held_req_kind_next;
            held_data_word_reg  <= held_data_word_next;
            held_data_count_reg <= held_data_count_next;
        end
    end

    assign s1 = s1_reg;

`ifndef ASSERT_OFF
    // Never hold both halves of a write at once
    a_one_half_held: assert property (@(posedge clk) disable iff (!rst_n)
        !(held_req_valid_reg && held_data_valid_reg))
        else $error("both write halves held");

    // Clearing pass writes every lane and blocks input
    a_clear_all_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (cmd.wr_en == '1) && (cmd.rd_en == '0) && !in_ready)
        else $error("clearing pass not writing all lanes");

    // A stalled stage keeps its item
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && !s1_ready |=> s1_reg.valid && $stable(s1_reg))
        else $error("stage item lost under stall");

    // No memory traffic from an item that is not accepted
    a_no_stray_access: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_reg && !accept |-> (cmd.wr_en == '0) && (cmd.rd_en == '0))
        else $error("memory access without accepted word");
`endif

endmodule

>>> sv/lsdm_resp.sv
// Result side: byte reassembly, sign/zero extension and the output register.
// Uses lsdm_pkg for the stage type and access kinds.
module lsdm_resp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lsdm_pkg::stage_t                s1,
    input  logic [lsdm_pkg::LANES-1:0][7:0] lane_data,
    output logic                            s1_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            response_kind,
    output logic [31:0]                     read_value,
    output logic [4:0]                      dest_tag,
    output logic [4:0]                      source_tag
);

    logic        out_valid_reg;
    logic        kind_reg,   kind_next;
    logic [31:0] value_reg,  value_next;
    logic [4:0]  dest_reg_q, src_reg_q;
    logic [31:0] raw;

    assign s1_ready = !out_valid_reg || out_ready;

    // Rotate lanes back into byte order
    always_comb
    begin
        for (int i = 0; i < lsdm_pkg::LANES; i++)
        begin
            raw[8*i +: 8] = lane_data[2'(i) + s1.off];
        end
    end

    // Extend the loaded value
    always_comb
    begin
        kind_next = (s1.rsp == lsdm_pkg::RESP_DONE);
        case (s1.kind)
            lsdm_pkg::KIND_LB:  value_next = {{24{raw[7]}}, raw[7:0]};
            lsdm_pkg::KIND_LBU: value_next = {24'h0, raw[7:0]};
            lsdm_pkg::KIND_LH:  value_next = {{16{raw[15]}}, raw[15:0]};
            lsdm_pkg::KIND_LHU: value_next = {16'h0, raw[15:0]};
            lsdm_pkg::KIND_LW:  value_next = raw;
            default:            value_next = 32'h0;
        endcase
        if (s1.rsp == lsdm_pkg::RESP_DONE)
        begin
            value_next = 32'h0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            out_valid_reg <= s1.valid;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && s1.valid)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            dest_reg_q <= (s1.rsp == lsdm_pkg::RESP_DONE) ? 5'd0 : s1.dest;
            src_reg_q  <= (s1.rsp == lsdm_pkg::RESP_DONE) ? 5'd0 : s1.src;
        end
    end

    assign out_valid     = out_valid_reg;
    assign response_kind = kind_reg;
    assign read_value    = value_reg;
    assign dest_tag      = dest_reg_q;
    assign source_tag    = src_reg_q;

endmodule

>>> sv/riscv_load_store_data_memory.sv
// Top level of the RV32I load/store data memory: four byte-lane RAMs,
// request side and result side. Uses lsdm_pkg, lsdm_access, lsdm_byte_ram, lsdm_resp.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------------
//  input   | in_valid / in_ready | operation access_kind address write_data
//          |                     | valid_bytes dest_reg source_reg
//  output  | out_valid/out_ready | response_kind read_value dest_tag source_tag
//
// One word is accepted per cycle while in_ready is high; a result passes through
// the registered RAM read and then the result register.
// After reset a clearing pass zeroes the memory one row of four bytes a cycle,
// with in_ready low throughout. A stalled result holds the stage behind it;
// outside the clearing pass, in_ready drops only when both are full.
module riscv_load_store_data_memory (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [2:0]  access_kind,
    input  logic [31:0] address,
    input  logic [31:0] write_data,
    input  logic [2:0]  valid_bytes,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  source_reg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        response_kind,
    output logic [31:0] read_value,
    output logic [4:0]  dest_tag,
    output logic [4:0]  source_tag
);

    lsdm_pkg::mem_cmd_t              cmd;
    lsdm_pkg::stage_t                s1;
    logic                            s1_ready;
    logic [lsdm_pkg::LANES-1:0][7:0] lane_data;

    lsdm_access u_access (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .access_kind (access_kind),
        .address     (address),
        .write_data  (write_data),
        .valid_bytes (valid_bytes),
        .dest_reg    (dest_reg),
        .source_reg  (source_reg),
        .s1_ready    (s1_ready),
        .s1          (s1),
        .cmd         (cmd)
    );

    // One RAM per byte lane
    for (genvar g = 0; g < lsdm_pkg::LANES; g++)
    begin : g_lane
        lsdm_byte_ram u_ram (
            .clk   (clk),
            .rd_en (cmd.rd_en[g]),
            .wr_en (cmd.wr_en[g]),
            .row   (cmd.row[g]),
            .wdata (cmd.wdata[g]),
            .rdata (lane_data[g])
        );
    end

    lsdm_resp u_resp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1            (s1),
        .lane_data     (lane_data),
        .s1_ready      (s1_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .response_kind (response_kind),
        .read_value    (read_value),
        .dest_tag      (dest_tag),
        .source_tag    (source_tag)
    );

endmodule
